### rtl/bsf_pkg.sv
package bsf_pkg;

    // Command codes of an input item.
    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Status codes of a result item.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_MARKER = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_XOR    = 8'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0] START_MARKER_RESET  = 8'd126;
    localparam logic [7:0] END_MARKER_RESET    = 8'd127;
    localparam logic [7:0] ESCAPE_MARKER_RESET = 8'd125;
    localparam logic [7:0] ESCAPE_XOR_RESET    = 8'd32;

    // Default depth of the job queue between front and back.
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    typedef struct packed {
        logic       command;
        logic [7:0] packet_id;
        logic [7:0] payload_length;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       frame_end;
        logic       run_last;
        logic       status;
    } out_item_t;

    typedef struct packed {
        logic [7:0] sof_byte;
        logic [7:0] eof_byte;
        logic [7:0] esc_byte;
        logic [7:0] esc_mask;
    } marker_t;

    typedef enum logic [1:0] {
        JOB_ERR,
        JOB_BEGIN,
        JOB_DATA
    } job_kind_t;

    // One classified item: byte_a is the id, byte_b the length or payload byte.
    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic       tail;
        logic [7:0] sum;
    } job_t;

    // Logical byte positions of a frame.
    typedef enum logic [2:0] {
        SLOT_START,
        SLOT_A,
        SLOT_B,
        SLOT_SUM,
        SLOT_END
    } slot_t;

endpackage

### rtl/bsf_front.sv
module bsf_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bsf_pkg::in_item_t s_item,
    output logic             push_valid,
    input  logic             push_ready,
    output bsf_pkg::job_t    push_job
);
    import bsf_pkg::*;

    logic       frame_open_reg, frame_open_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [7:0] begin_sum;
    logic [7:0] data_sum;
    logic [7:0] left_dec;
    logic       accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    assign begin_sum = s_item.packet_id + s_item.payload_length;
    assign data_sum  = running_sum_reg + s_item.data_byte;
    assign left_dec  = bytes_left_reg - 8'd1;

    // Classify the item against the frame state and work out the next state.
    always_comb begin
        push_job         = '0;
        push_job.kind    = JOB_ERR;
        frame_open_next  = frame_open_reg;
        bytes_left_next  = bytes_left_reg;
        running_sum_next = running_sum_reg;
        if (s_item.command == CMD_BEGIN) begin
            if (!frame_open_reg) begin
                push_job.kind   = JOB_BEGIN;
                push_job.byte_a = s_item.packet_id;
                push_job.byte_b = s_item.payload_length;
                push_job.sum    = begin_sum;
                push_job.tail   = (s_item.payload_length == 8'd0);
                if (s_item.payload_length != 8'd0) begin
                    frame_open_next  = 1'b1;
                    bytes_left_next  = s_item.payload_length;
                    running_sum_next = begin_sum;
                end
            end
        end else begin
            if (frame_open_reg) begin
                push_job.kind   = JOB_DATA;
                push_job.byte_b = s_item.data_byte;
                push_job.sum    = data_sum;
                push_job.tail   = (left_dec == 8'd0);
                if (left_dec == 8'd0) begin
                    frame_open_next  = 1'b0;
                    bytes_left_next  = 8'd0;
                    running_sum_next = 8'd0;
                end else begin
                    bytes_left_next  = left_dec;
                    running_sum_next = data_sum;
                end
            end
        end
    end

    // Frame state advances only on an accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg  <= 1'b0;
            bytes_left_reg  <= 8'd0;
            running_sum_reg <= 8'd0;
        end else if (accept) begin
            frame_open_reg  <= frame_open_next;
            bytes_left_reg  <= bytes_left_next;
            running_sum_reg <= running_sum_next;
        end
    end

    // A closed frame holds no count and no partial sum.
    a_closed_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !frame_open_reg |-> (bytes_left_reg == 8'd0 && running_sum_reg == 8'd0))
        else $error("closed frame holds stale state");

    // An open frame always expects at least one more payload byte.
    a_open_count: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_open_reg |-> (bytes_left_reg != 8'd0))
        else $error("open frame with no payload left");

endmodule

### rtl/bsf_queue.sv
module bsf_queue #(
    parameter int unsigned DEPTH = bsf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  bsf_pkg::job_t push_job,
    output logic          head_valid,
    input  logic          pop,
    output bsf_pkg::job_t head_job
);
    import bsf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // Pointer wrap and fill count.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // The fill count never passes the depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

### rtl/bsf_back.sv
module bsf_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  bsf_pkg::marker_t   markers,
    input  logic               head_valid,
    input  bsf_pkg::job_t      head_job,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output bsf_pkg::out_item_t m_result
);
    import bsf_pkg::*;

    slot_t     slot_reg, slot_next;
    logic      started_reg, started_next;
    logic      esc_phase_reg, esc_phase_next;
    logic      m_valid_reg, m_valid_next;
    out_item_t out_reg;

    slot_t     cur_slot;
    slot_t     last_slot;
    slot_t     succ_slot;
    logic [7:0] slot_byte;
    logic      slot_raw;
    logic      slot_is_end;
    logic      needs_esc;
    logic      load;
    logic      slot_done;
    logic      job_done;
    out_item_t result;

    assign load      = head_valid && (!m_valid_reg || m_ready);
    assign cur_slot  = started_reg ? slot_reg
                     : ((head_job.kind == JOB_BEGIN) ? SLOT_START : SLOT_B);
    assign last_slot = head_job.tail ? SLOT_END : SLOT_B;

    // Byte that belongs to the current slot.
    always_comb begin
        slot_byte   = 8'd0;
        slot_raw    = 1'b0;
        slot_is_end = 1'b0;
        succ_slot   = SLOT_END;
        case (cur_slot)
            SLOT_START: begin
                slot_byte = markers.sof_byte;
                slot_raw  = 1'b1;
                succ_slot = SLOT_A;
            end
            SLOT_A: begin
                slot_byte = head_job.byte_a;
                succ_slot = SLOT_B;
            end
            SLOT_B: begin
                slot_byte = head_job.byte_b;
                succ_slot = SLOT_SUM;
            end
            SLOT_SUM: begin
                slot_byte = head_job.sum;
                succ_slot = SLOT_END;
            end
            SLOT_END: begin
                slot_byte   = markers.eof_byte;
                slot_raw    = 1'b1;
                slot_is_end = 1'b1;
                succ_slot   = SLOT_END;
            end
            default: begin
                slot_byte = 8'd0;
            end
        endcase
    end

    assign needs_esc = !slot_raw && ((slot_byte == markers.sof_byte)
                     || (slot_byte == markers.eof_byte)
                     || (slot_byte == markers.esc_byte));

    // Result for this cycle, and whether the slot or the job completes.
    always_comb begin
        result    = '0;
        slot_done = 1'b0;
        job_done  = 1'b0;
        if (head_job.kind == JOB_ERR) begin
            result.status   = STATUS_BAD;
            result.run_last = 1'b1;
            job_done        = 1'b1;
        end else if (needs_esc && !esc_phase_reg) begin
            result.line_byte = markers.esc_byte;
        end else begin
            result.line_byte = esc_phase_reg ? (slot_byte ^ markers.esc_mask) : slot_byte;
            result.frame_end = slot_is_end;
            result.run_last  = (cur_slot == last_slot);
            slot_done        = 1'b1;
            job_done         = (cur_slot == last_slot);
        end
    end

    assign pop = load && job_done;

    // Sequencer next state.
    always_comb begin
        slot_next      = slot_reg;
        started_next   = started_reg;
        esc_phase_next = esc_phase_reg;
        if (load) begin
            if (job_done) begin
                started_next   = 1'b0;
                esc_phase_next = 1'b0;
                slot_next      = SLOT_START;
            end else if (slot_done) begin
                started_next   = 1'b1;
                esc_phase_next = 1'b0;
                slot_next      = succ_slot;
            end else begin
                started_next   = 1'b1;
                esc_phase_next = 1'b1;
                slot_next      = cur_slot;
            end
        end
    end

    // Output register valid.
    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg      <= SLOT_START;
            started_reg   <= 1'b0;
            esc_phase_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            slot_reg      <= slot_next;
            started_reg   <= started_next;
            esc_phase_reg <= esc_phase_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= result;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = out_reg;

    // The second half of an escape only happens inside a started job.
    a_esc_started: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_phase_reg |-> started_reg)
        else $error("escape phase outside a job");

endmodule

### rtl/byte_stuffed_packet_framer_top.sv
// Channel  | Ports                                  | Direction | Moves
// ---------+----------------------------------------+-----------+---------------------------
// input    | s_valid, s_ready, s_item               | in        | one command item
// result   | m_valid, m_ready, m_result             | out       | one line byte or a flag
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in     | one register write
//
// Each input item yields 1 to 8 result items, one per cycle while m_ready does not
// hold the single-byte output register of the back sequencer.
// The first result of an item passes through the job queue and then that register.
// Reset is synchronous, with aresetn low; there is no clearing pass.
// The job queue lets the input side keep accepting while the output is stalled,
// until the queue is full.
module byte_stuffed_packet_framer_top #(
    parameter int unsigned QUEUE_DEPTH = bsf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bsf_pkg::in_item_t                 s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bsf_pkg::out_item_t                m_result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bsf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [7:0]                        cfg_data
);
    import bsf_pkg::*;

    marker_t markers_reg;
    job_t    push_job;
    job_t    head_job;
    logic    push_valid;
    logic    push_ready;
    logic    head_valid;
    logic    pop;

    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            markers_reg.sof_byte <= START_MARKER_RESET;
            markers_reg.eof_byte <= END_MARKER_RESET;
            markers_reg.esc_byte <= ESCAPE_MARKER_RESET;
            markers_reg.esc_mask <= ESCAPE_XOR_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_START_MARKER:  markers_reg.sof_byte <= cfg_data;
                REG_END_MARKER:    markers_reg.eof_byte <= cfg_data;
                REG_ESCAPE_MARKER: markers_reg.esc_byte <= cfg_data;
                REG_ESCAPE_XOR:    markers_reg.esc_mask <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    bsf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    bsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .head_valid (head_valid),
        .pop        (pop),
        .head_job   (head_job)
    );

    bsf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .markers    (markers_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

endmodule

### tb/byte_stuffed_packet_framer_top_test.sv
`timescale 1ns / 100ps

module byte_stuffed_packet_framer_top_test;
    import bsf_pkg::*;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    in_item_t               s_item = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_item_t              m_result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data = '0;

    // Marker registers as the framer should hold them.
    logic [7:0] mk_start = START_MARKER_RESET;
    logic [7:0] mk_end   = END_MARKER_RESET;
    logic [7:0] mk_esc   = ESCAPE_MARKER_RESET;
    logic [7:0] mk_mask  = ESCAPE_XOR_RESET;

    // Frame state of the predictor.
    logic       frm_open = 1'b0;
    logic [7:0] pay_left = '0;
    logic [7:0] csum     = '0;

    // Line bytes produced by one input item, and all line bytes still due.
    out_item_t  step_out [8];
    int         step_cnt;
    out_item_t  line_bytes_due [$];

    int          fail_cnt = 0;
    int unsigned tx_burst = 0;
    bit          tx_gaps = 1'b1;
    rx_mode_t    rx_mode = RX_ALWAYS;
    int unsigned rx_tick = 0;

    byte_stuffed_packet_framer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Appends one line byte to the output of the current step.
    function automatic void add_byte(input logic [7:0] b, input logic is_end, input logic st);
        out_item_t r;
        r.line_byte = b;
        r.frame_end = is_end;
        r.run_last  = 1'b0;
        r.status    = st;
        step_out[step_cnt] = r;
        step_cnt++;
    endfunction

    // Any byte equal to one of the three markers goes out as escape plus masked byte.
    function automatic void add_stuffed(input logic [7:0] b);
        if (b == mk_start || b == mk_end || b == mk_esc) begin
            add_byte(mk_esc, 1'b0, STATUS_OK);
            add_byte(b ^ mk_mask, 1'b0, STATUS_OK);
        end else begin
            add_byte(b, 1'b0, STATUS_OK);
        end
    endfunction

    // Checksum and end marker close the frame.
    function automatic void close_frame();
        add_stuffed(csum);
        add_byte(mk_end, 1'b1, STATUS_OK);
        frm_open = 1'b0;
        pay_left = '0;
        csum     = '0;
    endfunction

    // Computes the line bytes that one accepted item causes and queues them.
    function automatic void frame_item(input in_item_t item);
        int i;
        step_cnt = 0;
        if (item.command == CMD_BEGIN) begin
            if (frm_open) begin
                add_byte(8'h00, 1'b0, STATUS_BAD);
            end else begin
                add_byte(mk_start, 1'b0, STATUS_OK);
                add_stuffed(item.packet_id);
                add_stuffed(item.payload_length);
                csum     = item.packet_id + item.payload_length;
                pay_left = item.payload_length;
                frm_open = 1'b1;
                if (item.payload_length == 8'd0) begin
                    close_frame();
                end
            end
        end else begin
            if (!frm_open) begin
                add_byte(8'h00, 1'b0, STATUS_BAD);
            end else begin
                add_stuffed(item.data_byte);
                csum     = csum + item.data_byte;
                pay_left = pay_left - 8'd1;
                if (pay_left == 8'd0) begin
                    close_frame();
                end
            end
        end
        step_out[step_cnt-1].run_last = 1'b1;
        for (i = 0; i < step_cnt; i++) begin
            line_bytes_due.push_back(step_out[i]);
        end
    endfunction

    function automatic in_item_t make_item(input logic cmd, input logic [7:0] id,
                                           input logic [7:0] len, input logic [7:0] data);
        in_item_t item;
        item.command        = cmd;
        item.packet_id      = id;
        item.payload_length = len;
        item.data_byte      = data;
        return item;
    endfunction

    // Random byte that hits the current markers fairly often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return mk_start;
            1:       return mk_end;
            2:       return mk_esc;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            return 8'd0;
        end else if (r < 90) begin
            return 8'($urandom_range(1, 8));
        end
        return 8'($urandom_range(9, 40));
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    // Sends one item, in bursts with random gaps when tx_gaps is set, then predicts its line bytes.
    task automatic send_item(input in_item_t item);
        int unsigned gap;
        if (tx_gaps && tx_burst == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            tx_burst = $urandom_range(1, 12);
        end
        if (tx_burst != 0) begin
            tx_burst--;
        end
        s_valid <= 1'b1;
        s_item  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        frame_item(item);
    endtask

    // Holds the sender until every predicted line byte has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (line_bytes_due.size() != 0) @(posedge aclk);
    endtask

    // One register write; valid drops only after the last write of a series.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (last) begin
            cfg_valid <= 1'b0;
        end
        case (idx)
            REG_START_MARKER:  mk_start = val;
            REG_END_MARKER:    mk_end   = val;
            REG_ESCAPE_MARKER: mk_esc   = val;
            REG_ESCAPE_XOR:    mk_mask  = val;
            default: ;
        endcase
    endtask

    task automatic set_markers(input logic [7:0] st, input logic [7:0] en,
                               input logic [7:0] es, input logic [7:0] mask);
        write_reg(REG_START_MARKER, st, 1'b0);
        write_reg(REG_END_MARKER, en, 1'b0);
        write_reg(REG_ESCAPE_MARKER, es, 1'b0);
        write_reg(REG_ESCAPE_XOR, mask, 1'b1);
    endtask

    // Frames with the reset markers, including escaped ids and checksums.
    task automatic test_default_framing();
        rx_mode = RX_PATTERN;
        tx_gaps = 1'b1;
        send_item(make_item(CMD_BEGIN, 8'h00, 8'h00, 8'h00));
        send_item(make_item(CMD_BEGIN, 8'hFF, 8'h03, 8'h00));
        send_item(make_item(CMD_DATA, 8'h00, 8'h00, 8'h00));
        send_item(make_item(CMD_DATA, 8'h00, 8'h00, 8'hFF));
        send_item(make_item(CMD_DATA, 8'h00, 8'h00, 8'h7E));
        send_item(make_item(CMD_BEGIN, 8'h7D, 8'h00, 8'h00));
        send_item(make_item(CMD_BEGIN, 8'h10, 8'h01, 8'h00));
        send_item(make_item(CMD_DATA, 8'h00, 8'h00, 8'h6E));
    endtask

    // Data outside a frame and begin inside a frame are flagged and ignored.
    task automatic test_misplaced_items();
        rx_mode = RX_RANDOM;
        send_item(make_item(CMD_DATA, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(CMD_BEGIN, 8'h05, 8'h01, 8'h00));
        send_item(make_item(CMD_BEGIN, 8'h7E, 8'hFF, 8'h7F));
        send_item(make_item(CMD_DATA, 8'h00, 8'h00, 8'h7D));
        send_item(make_item(CMD_DATA, 8'hA5, 8'h5A, 8'h33));
    endtask

    // Unusual marker settings: small values, coinciding markers, unknown indexes.
    task automatic test_marker_settings();
        wait_drained();
        rx_mode = RX_ALWAYS;
        tx_gaps = 1'b0;
        set_markers(8'h01, 8'h02, 8'h03, 8'hFF);
        send_item(make_item(CMD_BEGIN, 8'h03, 8'h02, 8'h00));
        send_item(make_item(CMD_DATA, 8'h00, 8'h00, 8'h01));
        send_item(make_item(CMD_DATA, 8'h00, 8'h00, 8'h02));
        wait_drained();
        set_markers(8'h00, 8'h00, 8'h00, 8'h00);
        send_item(make_item(CMD_BEGIN, 8'h00, 8'h01, 8'h00));
        send_item(make_item(CMD_DATA, 8'h00, 8'h00, 8'h00));
        wait_drained();
        set_markers(8'hFF, 8'hFF, 8'hFF, 8'h80);
        send_item(make_item(CMD_BEGIN, 8'hFF, 8'h01, 8'h00));
        send_item(make_item(CMD_DATA, 8'h00, 8'h00, 8'h80));
        wait_drained();
        write_reg(8'd4, 8'h55, 1'b0);
        write_reg(8'hFF, 8'hAA, 1'b1);
        send_item(make_item(CMD_BEGIN, 8'h55, 8'h00, 8'hAA));
        wait_drained();
        set_markers(START_MARKER_RESET, END_MARKER_RESET, ESCAPE_MARKER_RESET,
                    ESCAPE_XOR_RESET);
    endtask

    // Longest payload, with escape settings changed while the frame is open.
    task automatic test_longest_packet();
        rx_mode = RX_RANDOM;
        tx_gaps = 1'b1;
        send_item(make_item(CMD_BEGIN, pick_byte(), 8'hFF, 8'($urandom_range(0, 255))));
        repeat (120) begin
            send_item(make_item(CMD_DATA, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), pick_byte()));
        end
        wait_drained();
        write_reg(REG_ESCAPE_MARKER, 8'h10, 1'b0);
        write_reg(REG_ESCAPE_XOR, 8'h01, 1'b1);
        while (frm_open) begin
            send_item(make_item(CMD_DATA, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), pick_byte()));
        end
    endtask

    // Mostly well-formed packets with random content, some misplaced items mixed in.
    task automatic send_random_item();
        in_item_t item;
        item = make_item(CMD_DATA, pick_byte(), 8'($urandom_range(0, 255)), pick_byte());
        if (!frm_open) begin
            if ($urandom_range(0, 99) >= 8) begin
                item.command        = CMD_BEGIN;
                item.payload_length = pick_length();
            end
        end else if ($urandom_range(0, 99) < 6) begin
            item.command = CMD_BEGIN;
        end
        send_item(item);
    endtask

    // Random traffic in phases; each phase drains, then picks markers and flow control.
    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned phase_items;
        sent = 0;
        while (sent < 32) begin
            wait_drained();
            case ($urandom_range(0, 5))
                0: set_markers(START_MARKER_RESET, END_MARKER_RESET, ESCAPE_MARKER_RESET,
                               ESCAPE_XOR_RESET);
                1: set_markers(8'h00, 8'h00, 8'h00, 8'h00);
                2: set_markers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                3: set_markers(8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)),
                               8'($urandom_range(0, 8)), 8'($urandom_range(0, 255)));
                default: set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)));
            endcase
            rx_mode     = rx_mode_t'($urandom_range(0, 2));
            tx_gaps     = ($urandom_range(0, 3) != 0);
            phase_items = $urandom_range(8, 16);
            repeat (phase_items) send_random_item();
            sent += phase_items;
        end
    endtask

    // Result side: check each accepted item against the oldest prediction.
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (line_bytes_due.size() == 0) begin
                $error("result item with nothing expected: line_byte %0h status %0h",
                       m_result.line_byte, m_result.status);
                fail_cnt++;
            end else begin
                want = line_bytes_due.pop_front();
                check_field("line_byte", want.line_byte, m_result.line_byte);
                check_field("frame_end", 8'(want.frame_end), 8'(m_result.frame_end));
                check_field("run_last", 8'(want.run_last), 8'(m_result.run_last));
                check_field("status", 8'(want.status), 8'(m_result.status));
            end
        end
        // The receiver stalls according to the current mode.
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_ALWAYS: m_ready <= 1'b1;
            RX_RANDOM: m_ready <= ($urandom_range(0, 9) < 6);
            default:   m_ready <= ((rx_tick % 11) < 7);
        endcase
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_framing();
        test_misplaced_items();
        test_marker_settings();
        test_longest_packet();
        test_random_traffic();
        wait_drained();
        rx_mode = RX_ALWAYS;
        repeat (20) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("byte_stuffed_packet_framer_top_test passed");
        end else begin
            $display("byte_stuffed_packet_framer_top_test failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2000000;
        $display("byte_stuffed_packet_framer_top_test failed");
        $finish;
    end

endmodule
